@@ src/bsaz_pkg.sv @@
// ----------------------------------------------------------------------------
// bsaz_pkg
// Types, constants, microcode and slot numbering helpers for the bitmap
// slot allocator.
// ----------------------------------------------------------------------------
package bsaz_pkg;

    localparam int SLOT_COUNT  = 256;
    localparam int MAX_REQUEST = 64;

    localparam int ROW_W      = 16;
    localparam int ROW_LOG    = $clog2(ROW_W);
    localparam int ROWS       = (SLOT_COUNT + ROW_W - 1) / ROW_W;
    localparam int ROW_IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SEARCH_W   = $clog2(ROWS * ROW_W + 1);
    localparam int CNT_W      = $clog2(MAX_REQUEST + 1);

    localparam logic [1:0] ST_GRANT = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FREE  = 2'd3;

    typedef struct packed {
        logic               action;
        logic [6:0]         slot_count;
        logic signed [15:0] free_offset;
    } req_t;

    typedef struct packed {
        logic signed [7:0] granted_offset;
        logic [1:0]        status;
        logic              last;
    } rsp_t;

    typedef enum logic [1:0] {
        H_NONE,
        H_REQ,
        H_RSP
    } hold_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_READ,
        OP_GRANT,
        OP_SKIP,
        OP_FREE_RD,
        OP_FREE_WR,
        OP_EMPTY,
        OP_FAIL
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_FREE,
        C_ZERO,
        C_END,
        C_NO_FREE,
        C_MORE
    } cond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE    = 4'd0;
    localparam step_t S_DISP    = 4'd1;
    localparam step_t S_ZCHK    = 4'd2;
    localparam step_t S_READ    = 4'd3;
    localparam step_t S_TEST    = 4'd4;
    localparam step_t S_GRANT   = 4'd5;
    localparam step_t S_DONE    = 4'd6;
    localparam step_t S_SKIP    = 4'd7;
    localparam step_t S_FREE_RD = 4'd8;
    localparam step_t S_FREE_WR = 4'd9;
    localparam step_t S_EMPTY   = 4'd10;
    localparam step_t S_FAIL    = 4'd11;

    typedef struct packed {
        hold_t hold;
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic is_free;
        logic is_zero;
        logic at_end;
        logic no_free;
        logic more;
        logic rsp_busy;
    } flags_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            S_IDLE:    w = '{H_REQ,  OP_LOAD,    C_NEVER,   S_IDLE};
            S_DISP:    w = '{H_NONE, OP_NOP,     C_FREE,    S_FREE_RD};
            S_ZCHK:    w = '{H_NONE, OP_NOP,     C_ZERO,    S_EMPTY};
            S_READ:    w = '{H_NONE, OP_READ,    C_END,     S_FAIL};
            S_TEST:    w = '{H_NONE, OP_NOP,     C_NO_FREE, S_SKIP};
            S_GRANT:   w = '{H_RSP,  OP_GRANT,   C_MORE,    S_READ};
            S_DONE:    w = '{H_NONE, OP_NOP,     C_ALWAYS,  S_IDLE};
            S_SKIP:    w = '{H_NONE, OP_SKIP,    C_ALWAYS,  S_READ};
            S_FREE_RD: w = '{H_NONE, OP_FREE_RD, C_NEVER,   S_IDLE};
            S_FREE_WR: w = '{H_RSP,  OP_FREE_WR, C_ALWAYS,  S_IDLE};
            S_EMPTY:   w = '{H_RSP,  OP_EMPTY,   C_ALWAYS,  S_IDLE};
            S_FAIL:    w = '{H_RSP,  OP_FAIL,    C_ALWAYS,  S_IDLE};
            default:   w = '{H_NONE, OP_NOP,     C_ALWAYS,  S_IDLE};
        endcase
        return w;
    endfunction

    // signed offset to slot number: 2v, or -2v-1 when negative
    function automatic logic [15:0] zz_enc(input logic [15:0] v);
        logic [15:0] m;
        m = v[15] ? ~v : v;
        return {m[14:0], v[15]};
    endfunction

    // slot number to signed offset, low 8 bits
    function automatic logic [7:0] zz_dec(input logic [SEARCH_W-1:0] z);
        logic [SEARCH_W+7:0] w;
        w = {8'b0, z} >> 1;
        return z[0] ? ~w[7:0] : w[7:0];
    endfunction

endpackage

@@ src/bsaz_ram.sv @@
// ----------------------------------------------------------------------------
// bsaz_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bsaz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             ren,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/bsaz_seq.sv @@
// ----------------------------------------------------------------------------
// bsaz_seq
// Microcode sequencer: step counter, program table and jump logic.
// ----------------------------------------------------------------------------
module bsaz_seq
    import bsaz_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_stall,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    step_t  pc_reg;
    step_t  pc_next;
    uword_t uw;
    logic   go;
    logic   taken;

    assign uw = ucode(pc_reg);

    always_comb
    begin
        case (uw.hold)
            H_REQ:   go = req_valid;
            H_RSP:   go = !flags.rsp_busy;
            default: go = 1'b1;
        endcase
        case (uw.cond)
            C_ALWAYS:  taken = 1'b1;
            C_FREE:    taken = flags.is_free;
            C_ZERO:    taken = flags.is_zero;
            C_END:     taken = flags.at_end;
            C_NO_FREE: taken = flags.no_free;
            C_MORE:    taken = flags.more;
            default:   taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!go)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + step_t'(1);
        end
    end

    always_comb
    begin
        req_stall = (uw.hold != H_REQ);
        ctrl.op   = go ? uw.op : OP_NOP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ src/bsaz_dp.sv @@
// ----------------------------------------------------------------------------
// bsaz_dp
// Datapath: request registers, row-wise bitmap scan, used-mark RAM with
// per-row valid bits, and the result register.
// ----------------------------------------------------------------------------
module bsaz_dp
    import bsaz_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  ctrl_t  ctrl,
    input  req_t   req,
    output rsp_t   rsp,
    output logic   rsp_valid,
    input  logic   rsp_stall,
    output flags_t flags
);

    logic                  action_reg, action_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [15:0]           free_z_reg, free_z_next;
    logic [SEARCH_W-1:0]   search_reg, search_next;
    logic [ROWS-1:0]       row_valid_reg, row_valid_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic [ROW_IDX_W-1:0]  search_row;
    logic [ROW_LOG-1:0]    bit_off;
    logic [ROW_IDX_W-1:0]  free_row;
    logic [ROW_LOG-1:0]    free_bit;
    logic                  free_in_range;
    logic                  at_end;
    logic [ROW_W-1:0]      ram_rdata;
    logic [ROW_W-1:0]      row_data;
    logic [ROW_W-1:0]      avail;
    logic [ROW_LOG-1:0]    grant_idx;
    logic [SEARCH_W-1:0]   grant_slot;
    logic [ROW_W-1:0]      grant_mask;
    logic                  ren, we;
    logic [ROW_IDX_W-1:0]  raddr, waddr;
    logic [ROW_W-1:0]      wdata;
    logic                  rsp_load;

    assign search_row    = ROW_IDX_W'(search_reg >> ROW_LOG);
    assign bit_off       = search_reg[ROW_LOG-1:0];
    assign free_row      = ROW_IDX_W'(free_z_reg >> ROW_LOG);
    assign free_bit      = free_z_reg[ROW_LOG-1:0];
    assign free_in_range = (int'(free_z_reg) < SLOT_COUNT);
    assign at_end        = (search_reg >= SEARCH_W'(SLOT_COUNT));
    assign row_data      = rd_valid_reg ? ram_rdata : '0;

    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
        begin
            avail[j] = !row_data[j] && (j >= int'(bit_off))
                       && ((int'(search_row) * ROW_W + j) < SLOT_COUNT);
        end
        grant_idx = '0;
        for (int j = ROW_W - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                grant_idx = ROW_LOG'(j);
            end
        end
    end

    assign grant_slot = {search_reg[SEARCH_W-1:ROW_LOG], grant_idx};
    assign grant_mask = ROW_W'(1) << grant_idx;

    always_comb
    begin
        ren   = ((ctrl.op == OP_READ) && !at_end)
                || ((ctrl.op == OP_FREE_RD) && free_in_range);
        raddr = (ctrl.op == OP_FREE_RD) ? free_row : search_row;
        we    = (ctrl.op == OP_GRANT)
                || ((ctrl.op == OP_FREE_WR) && free_in_range);
        waddr = (ctrl.op == OP_GRANT) ? search_row : free_row;
        wdata = (ctrl.op == OP_GRANT) ? (row_data | grant_mask)
                                      : (row_data & ~(ROW_W'(1) << free_bit));
    end

    bsaz_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_marks (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .ren   (ren),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        action_next    = action_reg;
        cnt_next       = cnt_reg;
        free_z_next    = free_z_reg;
        search_next    = search_reg;
        row_valid_next = row_valid_reg;
        rd_valid_next  = rd_valid_reg;
        rsp_load       = 1'b0;
        rsp_next       = rsp_reg;

        if (ren)
        begin
            rd_valid_next = row_valid_reg[raddr];
        end
        if (we)
        begin
            row_valid_next[waddr] = 1'b1;
        end

        case (ctrl.op)
            OP_LOAD:
            begin
                action_next = req.action;
                cnt_next    = (int'(req.slot_count) > MAX_REQUEST)
                              ? CNT_W'(MAX_REQUEST) : CNT_W'(req.slot_count);
                free_z_next = zz_enc(req.free_offset);
                search_next = '0;
            end
            OP_GRANT:
            begin
                search_next = grant_slot + SEARCH_W'(1);
                cnt_next    = cnt_reg - CNT_W'(1);
                rsp_load    = 1'b1;
                rsp_next    = '{zz_dec(grant_slot), ST_GRANT,
                                cnt_reg == CNT_W'(1)};
            end
            OP_SKIP:
            begin
                search_next = {search_reg[SEARCH_W-1:ROW_LOG]
                               + (SEARCH_W-ROW_LOG)'(1), ROW_LOG'(0)};
            end
            OP_FREE_WR:
            begin
                rsp_load = 1'b1;
                rsp_next = '{8'sd0, ST_FREE, 1'b1};
            end
            OP_EMPTY:
            begin
                rsp_load = 1'b1;
                rsp_next = '{8'sd0, ST_EMPTY, 1'b1};
            end
            OP_FAIL:
            begin
                rsp_load = 1'b1;
                rsp_next = '{8'sd0, ST_FAIL, 1'b1};
            end
            default:
            begin
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        cnt_reg    <= cnt_next;
        free_z_reg <= free_z_next;
        search_reg <= search_next;
        rsp_reg    <= rsp_next;
    end

    assign flags.is_free  = action_reg;
    assign flags.is_zero  = (cnt_reg == '0);
    assign flags.at_end   = at_end;
    assign flags.no_free  = (avail == '0);
    assign flags.more     = (cnt_reg != CNT_W'(1));
    assign flags.rsp_busy = rsp_valid_reg && rsp_stall;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    a_grant_clear_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_GRANT) |-> ((row_data & grant_mask) == '0 && avail != '0))
        else $error("grant of a slot that is not free");

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_GRANT) |-> (int'(grant_slot) < SLOT_COUNT && cnt_reg != '0))
        else $error("grant beyond the bitmap or with no slots left to grant");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> !(rsp_valid_reg && rsp_stall))
        else $error("result register loaded while a transaction is pending");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != ST_GRANT) |-> rsp_reg.last)
        else $error("non-grant result without last");

endmodule

@@ src/bitmap_slot_allocator_zigzag.sv @@
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_zigzag
// First-fit allocator of time-division slots with zigzag slot offsets.
// ----------------------------------------------------------------------------
// An allocate request is scanned through a used-mark RAM of 16-bit rows, one
// row read per pass. Each grant steps through read, test and grant, and each
// row passed over without a free slot steps through read, test and skip; a
// request also passes through dispatch and completion steps, and the result
// channel can stall every step that loads a result. An empty request goes
// through dispatch and a zero check to its result; a free reads the slot's
// row, then clears its bit when the slot is in range. One request is handled
// at a time; the next is taken once the last result transaction is queued.
// The bitmap is all clear after reset with no clearing pass.
module bitmap_slot_allocator_zigzag
    import bsaz_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    ctrl_t  ctrl;
    flags_t flags;

    bsaz_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .flags     (flags),
        .ctrl      (ctrl)
    );

    bsaz_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .flags     (flags)
    );

endmodule
